// ===== rtl/core/code93_barcode_encoder_core_assert.svh =====
// Assertion macros for the Code 93 encoder core.
`ifndef CODE93_BARCODE_ENCODER_CORE_ASSERT_SVH
`define CODE93_BARCODE_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define C93_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define C93_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/c93enc_pkg.sv =====
package c93enc_pkg;

  localparam int unsigned STORE_DEPTH_DEF = 128;
  localparam int unsigned MOD47           = 47;
  localparam logic [7:0]  MAX_LEN_RST     = 8'd107;
  localparam logic [11:0] FRAME_PAT       = 12'b00_00_00_00_11_00;
  localparam logic        REG_MAX_LEN     = 1'b0;

  typedef enum logic [2:0] {
    KIND_START = 3'd0,
    KIND_DATA  = 3'd1,
    KIND_CHK_C = 3'd2,
    KIND_CHK_K = 3'd3,
    KIND_STOP  = 3'd4,
    KIND_BAD   = 3'd5,
    KIND_LONG  = 3'd6
  } kind_e;

  typedef struct packed {
    logic       two;
    logic [5:0] v0;
    logic [5:0] v1;
  } map_t;

  typedef struct packed {
    logic       we;
    logic       go;
    logic [5:0] wdata;
  } chk_ctrl_t;

  typedef struct packed {
    logic       done;
    logic [5:0] c;
    logic [5:0] k;
  } chk_stat_t;

  // Full-ASCII shift mapping: one or two symbol values per byte.
  function automatic map_t map_ascii(input logic [6:0] b);
    map_t       m;
    logic [7:0] x;
    x    = {1'b0, b};
    m.two = 1'b1;
    m.v0  = 6'd0;
    m.v1  = 6'd0;
    if (x == 8'd0) begin
      m.v0 = 6'd44; m.v1 = 6'd30;
    end else if (x <= 8'd26) begin
      m.v0 = 6'd43; m.v1 = 6'(x + 8'd9);
    end else if (x <= 8'd31) begin
      m.v0 = 6'd44; m.v1 = 6'(x - 8'd17);
    end else if (x == 8'd32) begin
      m.v0 = 6'd38; m.two = 1'b0;
    end else if (x <= 8'd35) begin
      m.v0 = 6'd45; m.v1 = 6'(x - 8'd23);
    end else if (x == 8'd36) begin
      m.v0 = 6'd39; m.two = 1'b0;
    end else if (x == 8'd37) begin
      m.v0 = 6'd42; m.two = 1'b0;
    end else if (x <= 8'd42) begin
      m.v0 = 6'd45; m.v1 = 6'(x - 8'd23);
    end else if (x == 8'd43) begin
      m.v0 = 6'd41; m.two = 1'b0;
    end else if (x == 8'd44) begin
      m.v0 = 6'd45; m.v1 = 6'd21;
    end else if (x == 8'd45) begin
      m.v0 = 6'd36; m.two = 1'b0;
    end else if (x == 8'd46) begin
      m.v0 = 6'd37; m.two = 1'b0;
    end else if (x == 8'd47) begin
      m.v0 = 6'd40; m.two = 1'b0;
    end else if (x <= 8'd57) begin
      m.v0 = 6'(x - 8'd48); m.two = 1'b0;
    end else if (x == 8'd58) begin
      m.v0 = 6'd45; m.v1 = 6'd35;
    end else if (x <= 8'd63) begin
      m.v0 = 6'd44; m.v1 = 6'(x - 8'd44);
    end else if (x == 8'd64) begin
      m.v0 = 6'd44; m.v1 = 6'd31;
    end else if (x <= 8'd90) begin
      m.v0 = 6'(x - 8'd55); m.two = 1'b0;
    end else if (x <= 8'd95) begin
      m.v0 = 6'd44; m.v1 = 6'(x - 8'd71);
    end else if (x == 8'd96) begin
      m.v0 = 6'd44; m.v1 = 6'd32;
    end else if (x <= 8'd122) begin
      m.v0 = 6'd46; m.v1 = 6'(x - 8'd87);
    end else begin
      m.v0 = 6'd44; m.v1 = 6'(x - 8'd98);
    end
    return m;
  endfunction

  // Element widths minus one, two bits each, first element on top.
  function automatic logic [11:0] sym_pattern(input logic [5:0] v);
    logic [11:0] p;
    case (v)
      6'd0:    p = 12'b00_10_00_00_00_01;
      6'd1:    p = 12'b00_00_00_01_00_10;
      6'd2:    p = 12'b00_00_00_10_00_01;
      6'd3:    p = 12'b00_00_00_11_00_00;
      6'd4:    p = 12'b00_01_00_00_00_10;
      6'd5:    p = 12'b00_01_00_01_00_01;
      6'd6:    p = 12'b00_01_00_10_00_00;
      6'd7:    p = 12'b00_00_00_00_00_11;
      6'd8:    p = 12'b00_10_00_01_00_00;
      6'd9:    p = 12'b00_11_00_00_00_00;
      6'd10:   p = 12'b01_00_00_00_00_10;
      6'd11:   p = 12'b01_00_00_01_00_01;
      6'd12:   p = 12'b01_00_00_10_00_00;
      6'd13:   p = 12'b01_01_00_00_00_01;
      6'd14:   p = 12'b01_01_00_01_00_00;
      6'd15:   p = 12'b01_10_00_00_00_00;
      6'd16:   p = 12'b00_00_01_00_00_10;
      6'd17:   p = 12'b00_00_01_01_00_01;
      6'd18:   p = 12'b00_00_01_10_00_00;
      6'd19:   p = 12'b00_01_01_00_00_01;
      6'd20:   p = 12'b00_10_01_00_00_00;
      6'd21:   p = 12'b00_00_00_00_01_10;
      6'd22:   p = 12'b00_00_00_01_01_01;
      6'd23:   p = 12'b00_00_00_10_01_00;
      6'd24:   p = 12'b00_01_00_00_01_01;
      6'd25:   p = 12'b00_10_00_00_01_00;
      6'd26:   p = 12'b01_00_01_00_00_01;
      6'd27:   p = 12'b01_00_01_01_00_00;
      6'd28:   p = 12'b01_00_00_00_01_01;
      6'd29:   p = 12'b01_00_00_01_01_00;
      6'd30:   p = 12'b01_01_00_00_01_00;
      6'd31:   p = 12'b01_01_01_00_00_00;
      6'd32:   p = 12'b00_00_01_00_01_01;
      6'd33:   p = 12'b00_00_01_01_01_00;
      6'd34:   p = 12'b00_01_01_00_01_00;
      6'd35:   p = 12'b00_01_10_00_00_00;
      6'd36:   p = 12'b00_01_00_00_10_00;
      6'd37:   p = 12'b10_00_00_00_00_01;
      6'd38:   p = 12'b10_00_00_01_00_00;
      6'd39:   p = 12'b10_01_00_00_00_00;
      6'd40:   p = 12'b00_00_01_00_10_00;
      6'd41:   p = 12'b00_00_10_00_01_00;
      6'd42:   p = 12'b01_00_00_00_10_00;
      6'd43:   p = 12'b00_01_00_01_01_00;
      6'd44:   p = 12'b10_00_01_00_00_00;
      6'd45:   p = 12'b10_00_00_00_01_00;
      6'd46:   p = 12'b00_01_01_01_00_00;
      default: p = 12'b00_00_00_00_00_00;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/code93_barcode_encoder_core.sv =====
// Channel   Direction  Handshake                      Beat
// --------  ---------  -----------------------------  ---------------------------------------
// command   in         start, busy (taken: !busy)     char_byte_i, last_i
// result    out        result_valid_o (one cycle)     kind_o, char_value_o, pattern_o,
//                                                     end_of_run_o
// config    in/out     APB psel/penable/pwrite/pready max_length at byte address 0
//
// A byte with one symbol value passes through S_DATA0, with two values through S_DATA0
// and S_DATA1, after S_START when the start beat goes first. After the last byte the
// check walk reads the single-port value store one entry a cycle, then the mod-47
// reduction runs through CK_RED1, CK_RED2 and CK_RED3, and C, K and stop are one beat each.
// Reset clears the message state and sets max_length to 107; the store needs no clear.
// Result beats leave at most one a cycle and cannot be held off.
module code93_barcode_encoder_core #(
  parameter int unsigned STORE_DEPTH = c93enc_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  char_byte_i,
  input  logic        last_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [5:0]  char_value_o,
  output logic [11:0] pattern_o,
  output logic        end_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import c93enc_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int LW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [LW-1:0] DEPTH_L = LW'(STORE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_START = 9'b000000010,
    S_DATA0 = 9'b000000100,
    S_DATA1 = 9'b000001000,
    S_ERR   = 9'b000010000,
    S_WALK  = 9'b000100000,
    S_CHKC  = 9'b001000000,
    S_CHKK  = 9'b010000000,
    S_STOP  = 9'b100000000
  } state_e;

  state_e        state_q, state_d;
  logic [7:0]    max_len_q, max_len_d;
  logic [CW-1:0] count_q, count_d;
  logic          started_q, started_d;
  logic          failed_q, failed_d;
  logic          last_q, last_d;
  logic          err_q, err_d;
  logic          bad_q, bad_d;
  map_t          map_q, map_d;

  logic          res_valid_q, res_valid_d;
  kind_e         res_kind_q, res_kind_d;
  logic [5:0]    res_val_q, res_val_d;
  logic [11:0]   res_pat_q, res_pat_d;
  logic          res_eor_q, res_eor_d;

  logic          accept;
  logic          cfg_wr;
  map_t          map_in;
  logic [LW-1:0] limit, need;
  chk_ctrl_t     chk_ctrl;
  chk_stat_t     chk_stat;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);
  assign prdata = (paddr[2] == REG_MAX_LEN) ? {24'b0, max_len_q} : 32'b0;

  assign map_in = map_ascii(char_byte_i[6:0]);
  assign limit  = (LW'(max_len_q) > DEPTH_L) ? DEPTH_L : LW'(max_len_q);
  assign need   = LW'(count_q) + (map_in.two ? LW'(2) : LW'(1));

  always_comb begin
    state_d     = state_q;
    max_len_d   = cfg_wr ? pwdata[7:0] : max_len_q;
    count_d     = count_q;
    started_d   = started_q;
    failed_d    = failed_q;
    last_d      = last_q;
    err_d       = err_q;
    bad_d       = bad_q;
    map_d       = map_q;
    res_valid_d = 1'b0;
    res_kind_d  = res_kind_q;
    res_val_d   = res_val_q;
    res_pat_d   = res_pat_q;
    res_eor_d   = res_eor_q;
    chk_ctrl.we    = 1'b0;
    chk_ctrl.go    = 1'b0;
    chk_ctrl.wdata = map_q.v0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (failed_q) begin
            // Drop the byte; the last one closes the message.
            if (last_i) begin
              count_d   = '0;
              started_d = 1'b0;
              failed_d  = 1'b0;
            end
          end else begin
            map_d  = map_in;
            last_d = last_i;
            bad_d  = char_byte_i[7];
            err_d  = char_byte_i[7] || (need > limit);
            if (!started_q) begin
              state_d = S_START;
            end else if (char_byte_i[7] || (need > limit)) begin
              state_d = S_ERR;
            end else begin
              state_d = S_DATA0;
            end
          end
        end
      end
      S_START: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_START;
        res_val_d   = 6'd0;
        res_pat_d   = FRAME_PAT;
        res_eor_d   = 1'b0;
        started_d   = 1'b1;
        state_d     = err_q ? S_ERR : S_DATA0;
      end
      S_DATA0: begin
        chk_ctrl.we = 1'b1;
        res_valid_d = 1'b1;
        res_kind_d  = KIND_DATA;
        res_val_d   = map_q.v0;
        res_pat_d   = sym_pattern(map_q.v0);
        res_eor_d   = !map_q.two && !last_q;
        count_d     = count_q + 1'b1;
        if (map_q.two) begin
          state_d = S_DATA1;
        end else if (last_q) begin
          state_d = S_WALK;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DATA1: begin
        chk_ctrl.we    = 1'b1;
        chk_ctrl.wdata = map_q.v1;
        res_valid_d    = 1'b1;
        res_kind_d     = KIND_DATA;
        res_val_d      = map_q.v1;
        res_pat_d      = sym_pattern(map_q.v1);
        res_eor_d      = !last_q;
        count_d        = count_q + 1'b1;
        state_d        = last_q ? S_WALK : S_IDLE;
      end
      S_ERR: begin
        res_valid_d = 1'b1;
        res_kind_d  = bad_q ? KIND_BAD : KIND_LONG;
        res_val_d   = 6'd0;
        res_pat_d   = 12'd0;
        res_eor_d   = 1'b1;
        if (last_q) begin
          count_d   = '0;
          started_d = 1'b0;
          failed_d  = 1'b0;
        end else begin
          failed_d  = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_WALK: begin
        chk_ctrl.go = 1'b1;
        if (chk_stat.done) begin
          state_d = S_CHKC;
        end
      end
      S_CHKC: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_CHK_C;
        res_val_d   = chk_stat.c;
        res_pat_d   = sym_pattern(chk_stat.c);
        res_eor_d   = 1'b0;
        state_d     = S_CHKK;
      end
      S_CHKK: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_CHK_K;
        res_val_d   = chk_stat.k;
        res_pat_d   = sym_pattern(chk_stat.k);
        res_eor_d   = 1'b0;
        state_d     = S_STOP;
      end
      S_STOP: begin
        res_valid_d = 1'b1;
        res_kind_d  = KIND_STOP;
        res_val_d   = 6'd0;
        res_pat_d   = FRAME_PAT;
        res_eor_d   = 1'b1;
        count_d     = '0;
        started_d   = 1'b0;
        failed_d    = 1'b0;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_len_q   <= MAX_LEN_RST;
      count_q     <= '0;
      started_q   <= 1'b0;
      failed_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_len_q   <= max_len_d;
      count_q     <= count_d;
      started_q   <= started_d;
      failed_q    <= failed_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q     <= last_d;
    err_q      <= err_d;
    bad_q      <= bad_d;
    map_q      <= map_d;
    res_kind_q <= res_kind_d;
    res_val_q  <= res_val_d;
    res_pat_q  <= res_pat_d;
    res_eor_q  <= res_eor_d;
  end

  c93enc_check #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_check (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (chk_ctrl),
    .addr_i  (count_q[AW-1:0]),
    .count_i (count_q),
    .stat_o  (chk_stat)
  );

  assign result_valid_o = res_valid_q;
  assign kind_o         = res_kind_q;
  assign char_value_o   = res_val_q;
  assign pattern_o      = res_pat_q;
  assign end_of_run_o   = res_eor_q;

`include "code93_barcode_encoder_core_assert.svh"

  `C93_ASSERT_NOW(a_eor_idle, res_valid_q && res_eor_q, !busy, "run ended while still busy")
  `C93_ASSERT_NEXT(a_start_follow, res_valid_q && (res_kind_q == KIND_START), res_valid_q, "start beat not followed by a beat")
  `C93_ASSERT_NOW(a_walk_nonempty, state_q == S_WALK, count_q != '0, "check walk over an empty store")
  `C93_ASSERT_NEXT(a_drop_quiet, accept && failed_q, !busy && !res_valid_q, "dropped byte produced work")

endmodule

// ===== rtl/core/c93enc_check.sv =====
module c93enc_check #(
  parameter int unsigned STORE_DEPTH = c93enc_pkg::STORE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  c93enc_pkg::chk_ctrl_t              ctrl_i,
  input  logic [$clog2(STORE_DEPTH)-1:0]     addr_i,
  input  logic [$clog2(STORE_DEPTH+1)-1:0]   count_i,
  output c93enc_pkg::chk_stat_t              stat_o
);
  import c93enc_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int SUM_W = $clog2(STORE_DEPTH * 920 + 1);
  localparam int RECIP = (1 << SUM_W) / MOD47;
  localparam logic [SUM_W-1:0] RECIP_V = SUM_W'(RECIP);
  localparam logic [SUM_W-1:0] M47_W   = SUM_W'(MOD47);
  localparam logic [6:0]       M47_7   = 7'(MOD47);

  typedef enum logic [4:0] {
    CK_IDLE = 5'b00001,
    CK_WALK = 5'b00010,
    CK_RED1 = 5'b00100,
    CK_RED2 = 5'b01000,
    CK_RED3 = 5'b10000
  } ck_state_e;

  ck_state_e         state_q, state_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     left_q, left_d;
  logic              rvld_q, rvld_d;
  logic [4:0]        wc_q, wc_d;
  logic [3:0]        wk_q, wk_d;
  logic [SUM_W-1:0]  sc_q, sc_d, sk_q, sk_d;
  logic [SUM_W-1:0]  qc_q, qc_d, qk_q, qk_d;
  logic [5:0]        c_q, c_d, kr_q, kr_d, k_q, k_d;

  logic [5:0]        store_mem [STORE_DEPTH];
  logic [5:0]        rd_data_q;
  logic [AW-1:0]     mem_addr;
  logic              walk_rd;

  logic [10:0]       prod_c, prod_k;
  logic [2*SUM_W-1:0] mul_c, mul_k;
  logic [SUM_W-1:0]  rem_c, rem_k;
  logic [6:0]        fix_c, fix_k, k_sum;
  logic [CW-1:0]     cnt_m1;

  assign walk_rd  = (state_q == CK_WALK) && (left_q != '0);
  assign mem_addr = ctrl_i.we ? addr_i : idx_q;

  // Single-port store: one write or one read a cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      store_mem[mem_addr] <= ctrl_i.wdata;
    end
    rd_data_q <= store_mem[mem_addr];
  end

  assign prod_c = {5'b0, rd_data_q} * {6'b0, wc_q};
  assign prod_k = {5'b0, rd_data_q} * {7'b0, wk_q};
  assign mul_c  = {{SUM_W{1'b0}}, sc_q} * {{SUM_W{1'b0}}, RECIP_V};
  assign mul_k  = {{SUM_W{1'b0}}, sk_q} * {{SUM_W{1'b0}}, RECIP_V};
  assign rem_c  = sc_q - qc_q * M47_W;
  assign rem_k  = sk_q - qk_q * M47_W;
  assign fix_c  = (rem_c[6:0] >= M47_7) ? rem_c[6:0] - M47_7 : rem_c[6:0];
  assign fix_k  = (rem_k[6:0] >= M47_7) ? rem_k[6:0] - M47_7 : rem_k[6:0];
  assign k_sum  = {1'b0, c_q} + {1'b0, kr_q};
  assign cnt_m1 = count_i - 1'b1;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    left_d  = left_q;
    rvld_d  = 1'b0;
    wc_d    = wc_q;
    wk_d    = wk_q;
    sc_d    = sc_q;
    sk_d    = sk_q;
    qc_d    = qc_q;
    qk_d    = qk_q;
    c_d     = c_q;
    kr_d    = kr_q;
    k_d     = k_q;
    case (state_q)
      CK_IDLE: begin
        if (ctrl_i.go) begin
          idx_d   = cnt_m1[AW-1:0];
          left_d  = count_i;
          wc_d    = 5'd1;
          wk_d    = 4'd2;
          sc_d    = '0;
          sk_d    = '0;
          state_d = CK_WALK;
        end
      end
      CK_WALK: begin
        // Issue reads from the newest value down; accumulate in the cycle after each read.
        if (walk_rd) begin
          rvld_d = 1'b1;
          idx_d  = idx_q - 1'b1;
          left_d = left_q - 1'b1;
        end
        if (rvld_q) begin
          sc_d = sc_q + SUM_W'(prod_c);
          sk_d = sk_q + SUM_W'(prod_k);
          wc_d = (wc_q == 5'd20) ? 5'd1 : wc_q + 5'd1;
          wk_d = (wk_q == 4'd15) ? 4'd1 : wk_q + 4'd1;
        end
        if ((left_q == '0) && !rvld_q) begin
          state_d = CK_RED1;
        end
      end
      CK_RED1: begin
        qc_d    = mul_c[2*SUM_W-1:SUM_W];
        qk_d    = mul_k[2*SUM_W-1:SUM_W];
        state_d = CK_RED2;
      end
      CK_RED2: begin
        c_d     = fix_c[5:0];
        kr_d    = fix_k[5:0];
        state_d = CK_RED3;
      end
      CK_RED3: begin
        k_d     = (k_sum >= M47_7) ? 6'(k_sum - M47_7) : k_sum[5:0];
        state_d = CK_IDLE;
      end
      default: begin
        state_d = CK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CK_IDLE;
      rvld_q  <= 1'b0;
      left_q  <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rvld_d;
      left_q  <= left_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    wc_q   <= wc_d;
    wk_q   <= wk_d;
    sc_q   <= sc_d;
    sk_q   <= sk_d;
    qc_q   <= qc_d;
    qk_q   <= qk_d;
    kr_q   <= kr_d;
  end

  assign stat_o.done = (state_q == CK_RED3);
  assign stat_o.c    = c_q;
  assign stat_o.k    = k_q;

endmodule
